>>> sv/lra_pkg.sv
`timescale 1ns / 1ps

package lra_pkg;

    // default store sizes
    localparam int LRA_MAX_IN   = 256;
    localparam int LRA_MAX_OUT  = 64;
    localparam int LRA_MAX_RANK = 16;

    // item kinds carried on tuser
    localparam logic [2:0] MODE_DOWN  = 3'd0;
    localparam logic [2:0] MODE_UP    = 3'd1;
    localparam logic [2:0] MODE_INPUT = 3'd2;
    localparam logic [2:0] MODE_BASE  = 3'd3;
    localparam logic [2:0] MODE_START = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_IN_COUNT  = 2'd0;
    localparam logic [1:0] REG_OUT_COUNT = 2'd1;
    localparam logic [1:0] REG_RANK      = 2'd2;
    localparam logic [1:0] REG_SCALE     = 2'd3;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // clip a 64-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > S32_MAX) begin
            y = 32'sh7FFFFFFF;
        end else if (x < S32_MIN) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

>>> sv/low_rank_adapter_matvec_unit.sv
`timescale 1ns / 1ps

// Low-rank adapter update of an output vector, out[o] += scale * up[o] . (down * in), all Q16.16.
// Load items (down weight, up weight, input element, base output) are taken back to back while
// the block is idle; loads with indexes beyond the configured sizes are dropped. A start item
// runs a small sequencer around one shared 32x32 multiplier and one 64-bit accumulator, with
// every store read through a registered port. Each product takes a read, a multiply and an
// accumulate step, and the input stays stalled from the start transfer until the sequencer is
// back in idle; while an output waits for the previous result to be taken, the stall grows. The
// last result is held in the output register and may wait there while new loads come in.
// Stores power up with undefined contents and have no clearing pass; the user must see that
// configuration is written through the plain write port only while no start is running and no
// result is pending; the block itself does not enforce this.
module low_rank_adapter_matvec_unit
    import lra_pkg::*;
#(
    parameter int MAX_IN   = LRA_MAX_IN,
    parameter int MAX_OUT  = LRA_MAX_OUT,
    parameter int MAX_RANK = LRA_MAX_RANK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // row [7:0], column [15:8], value [47:16]
    input  logic [2:0]  i_s_tuser,   // mode [2:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_index [5:0], out_value [37:6], zero fill [39:38]
    output logic        o_m_tlast
);

    localparam int IN_CW  = $clog2(MAX_IN + 1);
    localparam int OUT_CW = $clog2(MAX_OUT + 1);
    localparam int RK_CW  = $clog2(MAX_RANK + 1);
    localparam int IN_AW  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int OUT_AW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int RK_AW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int DN_D   = MAX_RANK * MAX_IN;
    localparam int UP_D   = MAX_OUT * MAX_RANK;
    localparam int DN_AW  = (DN_D > 1) ? $clog2(DN_D) : 1;
    localparam int UP_AW  = (UP_D > 1) ? $clog2(UP_D) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LAT_RD  = 4'd1;
    localparam logic [3:0] S_LAT_MUL = 4'd2;
    localparam logic [3:0] S_LAT_ACC = 4'd3;
    localparam logic [3:0] S_LAT_WR  = 4'd4;
    localparam logic [3:0] S_UP_RD   = 4'd5;
    localparam logic [3:0] S_UP_MUL  = 4'd6;
    localparam logic [3:0] S_UP_ACC  = 4'd7;
    localparam logic [3:0] S_SC_MUL  = 4'd8;
    localparam logic [3:0] S_SC_ADD  = 4'd9;

    // stores
    logic signed [31:0] down_mem [DN_D];
    logic signed [31:0] up_mem   [UP_D];
    logic signed [31:0] in_mem   [MAX_IN];
    logic signed [31:0] base_mem [MAX_OUT];
    logic signed [31:0] lat_mem  [MAX_RANK];

    // configuration
    logic [8:0]         r_in_count;
    logic [6:0]         r_out_count;
    logic [4:0]         r_rank;
    logic signed [31:0] r_scale;

    // sequencer and datapath
    logic [3:0]         r_state, n_state;
    logic [RK_CW-1:0]   r_r, n_r;
    logic [IN_CW-1:0]   r_i, n_i;
    logic [OUT_CW-1:0]  r_o, n_o;
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_prod;
    logic               r_out_valid, n_out_valid;
    logic [5:0]         r_out_index;
    logic signed [31:0] r_out_value;
    logic               r_out_last;

    // registered store reads
    logic signed [31:0] r_down_q, r_in_q, r_up_q, r_lat_q, r_base_q;

    logic [IN_CW-1:0]   w_n_in;
    logic [OUT_CW-1:0]  w_n_out;
    logic [RK_CW-1:0]   w_n_rank;
    logic               w_i_last, w_r_last, w_o_last;
    logic               w_accept, w_start, w_sc_go;
    logic               w_ld_down, w_ld_up, w_ld_in, w_ld_base;
    logic [2:0]         w_mode;
    logic [7:0]         w_row, w_col;
    logic signed [31:0] w_val;
    logic [DN_AW-1:0]   w_down_waddr, w_down_raddr;
    logic [UP_AW-1:0]   w_up_waddr, w_up_raddr;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod, w_acc_sum;
    logic signed [31:0] w_acc_sat, w_res;
    logic               w_base_we;
    logic [OUT_AW-1:0]  w_base_waddr;
    logic signed [31:0] w_base_wdata;

    // effective sizes, register values clamped to the store sizes
    always_comb begin
        w_n_in   = (32'(r_in_count) > 32'(MAX_IN)) ? IN_CW'(MAX_IN) : IN_CW'(r_in_count);
        w_n_out  = (32'(r_out_count) > 32'(MAX_OUT)) ? OUT_CW'(MAX_OUT) : OUT_CW'(r_out_count);
        w_n_rank = (32'(r_rank) > 32'(MAX_RANK)) ? RK_CW'(MAX_RANK) : RK_CW'(r_rank);
    end

    assign w_i_last = (32'(r_i) + 32'd1) >= 32'(w_n_in);
    assign w_r_last = (32'(r_r) + 32'd1) >= 32'(w_n_rank);
    assign w_o_last = (32'(r_o) + 32'd1) >= 32'(w_n_out);

    // input transfer decode
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_mode     = i_s_tuser;
    assign w_row      = i_s_tdata[7:0];
    assign w_col      = i_s_tdata[15:8];
    assign w_val      = i_s_tdata[47:16];
    assign w_start    = w_accept && (w_mode == MODE_START);
    assign w_ld_down  = w_accept && (w_mode == MODE_DOWN) &&
                        (32'(w_row) < 32'(w_n_rank)) && (32'(w_col) < 32'(w_n_in));
    assign w_ld_up    = w_accept && (w_mode == MODE_UP) &&
                        (32'(w_row) < 32'(w_n_out)) && (32'(w_col) < 32'(w_n_rank));
    assign w_ld_in    = w_accept && (w_mode == MODE_INPUT) && (32'(w_col) < 32'(w_n_in));
    assign w_ld_base  = w_accept && (w_mode == MODE_BASE) && (32'(w_col) < 32'(w_n_out));

    // store addresses
    assign w_down_waddr = DN_AW'(32'(w_row) * 32'(MAX_IN) + 32'(w_col));
    assign w_down_raddr = DN_AW'(32'(r_r) * 32'(MAX_IN) + 32'(r_i));
    assign w_up_waddr   = UP_AW'(32'(w_row) * 32'(MAX_RANK) + 32'(w_col));
    assign w_up_raddr   = UP_AW'(32'(r_o) * 32'(MAX_RANK) + 32'(r_r));

    // shared multiplier operand select
    always_comb begin
        if (r_state == S_SC_MUL) begin
            w_mul_a = r_scale;
            w_mul_b = w_acc_sat;
        end else if (r_state == S_UP_MUL) begin
            w_mul_a = r_up_q;
            w_mul_b = r_lat_q;
        end else begin
            w_mul_a = r_down_q;
            w_mul_b = r_in_q;
        end
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_acc_sum = r_acc + (r_prod >>> 16);
    assign w_acc_sat = sat32(r_acc);
    assign w_res     = sat32(64'(r_base_q) + (r_prod >>> 16));
    assign w_sc_go   = (r_state == S_SC_ADD) && (!r_out_valid || i_m_tready);

    // base store write: loads, or write-back of the updated output
    always_comb begin
        w_base_we    = w_ld_base || w_sc_go;
        w_base_waddr = w_sc_go ? r_o[OUT_AW-1:0] : OUT_AW'(w_col);
        w_base_wdata = w_sc_go ? w_res : w_val;
    end

    // stores with registered reads
    always_ff @(posedge i_clk) begin
        if (w_ld_down) begin
            down_mem[w_down_waddr] <= w_val;
        end
        r_down_q <= down_mem[w_down_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_in) begin
            in_mem[IN_AW'(w_col)] <= w_val;
        end
        r_in_q <= in_mem[r_i[IN_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_up) begin
            up_mem[w_up_waddr] <= w_val;
        end
        r_up_q <= up_mem[w_up_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_base_we) begin
            base_mem[w_base_waddr] <= w_base_wdata;
        end
        r_base_q <= base_mem[r_o[OUT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LAT_WR) begin
            lat_mem[r_r[RK_AW-1:0]] <= w_acc_sat;
        end
        r_lat_q <= lat_mem[r_r[RK_AW-1:0]];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_r         = r_r;
        n_i         = r_i;
        n_o         = r_o;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_r     = '0;
                    n_i     = '0;
                    n_o     = '0;
                    n_acc   = '0;
                    n_state = S_LAT_RD;
                end
            end
            S_LAT_RD: begin
                if (w_n_rank == '0) begin
                    n_state = (w_n_out == '0) ? S_IDLE : S_UP_RD;
                end else if (w_n_in == '0) begin
                    n_state = S_LAT_WR;
                end else begin
                    n_state = S_LAT_MUL;
                end
            end
            S_LAT_MUL: begin
                n_state = S_LAT_ACC;
            end
            S_LAT_ACC: begin
                n_acc = w_acc_sum;
                if (w_i_last) begin
                    n_state = S_LAT_WR;
                end else begin
                    n_i     = r_i + IN_CW'(1);
                    n_state = S_LAT_RD;
                end
            end
            S_LAT_WR: begin
                n_acc = '0;
                n_i   = '0;
                if (w_r_last) begin
                    n_r     = '0;
                    n_state = (w_n_out == '0) ? S_IDLE : S_UP_RD;
                end else begin
                    n_r     = r_r + RK_CW'(1);
                    n_state = S_LAT_RD;
                end
            end
            S_UP_RD: begin
                n_state = (w_n_rank == '0) ? S_SC_MUL : S_UP_MUL;
            end
            S_UP_MUL: begin
                n_state = S_UP_ACC;
            end
            S_UP_ACC: begin
                n_acc = w_acc_sum;
                if (w_r_last) begin
                    n_state = S_SC_MUL;
                end else begin
                    n_r     = r_r + RK_CW'(1);
                    n_state = S_UP_RD;
                end
            end
            S_SC_MUL: begin
                n_state = S_SC_ADD;
            end
            S_SC_ADD: begin
                if (w_sc_go) begin
                    n_out_valid = 1'b1;
                    n_r         = '0;
                    n_acc       = '0;
                    if (w_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_o     = r_o + OUT_CW'(1);
                        n_state = S_UP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_r         <= '0;
            r_i         <= '0;
            r_o         <= '0;
            r_out_valid <= 1'b0;
            r_in_count  <= 9'd256;
            r_out_count <= 7'd64;
            r_rank      <= 5'd16;
            r_scale     <= 32'sd65536;
        end else begin
            r_state     <= n_state;
            r_r         <= n_r;
            r_i         <= n_i;
            r_o         <= n_o;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IN_COUNT:  r_in_count  <= i_cfg_data[8:0];
                    REG_OUT_COUNT: r_out_count <= i_cfg_data[6:0];
                    REG_RANK:      r_rank      <= i_cfg_data[4:0];
                    REG_SCALE:     r_scale     <= i_cfg_data;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_state == S_LAT_MUL || r_state == S_UP_MUL || r_state == S_SC_MUL) begin
            r_prod <= w_prod;
        end
        if (w_sc_go) begin
            r_out_index <= 6'(r_o);
            r_out_value <= w_res;
            r_out_last  <= w_o_last;
        end
    end

    // result port
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_value, r_out_index};
    assign o_m_tlast  = r_out_last;

    // a computed output never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_ADD && r_out_valid && !i_m_tready) |=> (r_state == S_SC_ADD))
        else $error("output register overwritten while a result is pending");

    // emitted index stays within the configured outputs
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[5:0]) < 32'(w_n_out)))
        else $error("result index beyond the output count");

    // last marks exactly the final output index
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == ((32'(o_m_tdata[5:0]) + 32'd1) == 32'(w_n_out))))
        else $error("tlast does not match the final output index");

    // latent row counter stays within the rank during the latent phase
    a_lat_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAT_MUL || r_state == S_LAT_ACC || r_state == S_LAT_WR)
        |-> (32'(r_r) < 32'(w_n_rank)))
        else $error("latent row counter out of range");

endmodule
